// File: rtl/core/sps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg
// shared constants, state codes and controller/datapath interface types for
// the strided prime scanner
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int VALUE_BITS   = 27;
    localparam int STRIDE       = 16;
    localparam int WINDOW_DEPTH = 10;

    localparam int CFG_BITS     = 27;
    localparam int CFG_INDEX_W  = 2;
    localparam int COUNT_BITS   = 27;
    localparam int SUM_BITS     = 56;
    localparam int KEPT_BITS    = 4;
    localparam int KEPT_MAX     = (1 << KEPT_BITS) - 1;

    localparam logic [CFG_INDEX_W-1:0] REG_START_VALUE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE   = CFG_INDEX_W'(1);

    localparam logic [CFG_BITS-1:0] START_VALUE_RESET = CFG_BITS'(3);
    localparam logic [CFG_BITS-1:0] MAX_VALUE_RESET   = CFG_BITS'(100000000);

    // trial divisor and its square
    localparam int DIV_W = VALUE_BITS / 2 + 2;
    localparam int SQ_W  = VALUE_BITS + 1;
    localparam int FIRST_DIVISOR = 3;

    // remainder unit: a few dividend bits per cycle
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_PAD    = DIV_CYCLES * DIV_STEP;
    localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // recent prime window
    localparam int WIN_IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_TEST,
        ST_DIV,
        ST_REM,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic test_init;
        logic div_init;
        logic div_step;
        logic next_div;
        logic commit;
        logic commit_prime;
        logic commit_done;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic sq_over;
        logic div_last;
        logic rem_zero;
    } dp_status_t;

endpackage : sps_pkg
`default_nettype wire

// File: rtl/core/sps_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_ctrl
// sequencer for one scan step: restart, end check, trial division loop,
// commit and hand-off to the output register
// ----------------------------------------------------------------------------
module sps_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire sps_pkg::dp_status_t status,
    output sps_pkg::dp_cmd_t         cmd
);
    import sps_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (status.scan_done)
                    state_next = ST_FINISH;
                else
                    state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (status.sq_over)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_REM;
            end
            ST_REM:
            begin
                if (status.rem_zero)
                    state_next = ST_FINISH;
                else
                    state_next = ST_TEST;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_EVAL:
            begin
                if (status.scan_done)
                    cmd.commit_done = 1'b1;
                else
                    cmd.test_init = 1'b1;
            end
            ST_TEST:
            begin
                if (status.sq_over)
                begin
                    cmd.commit       = 1'b1;
                    cmd.commit_prime = 1'b1;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_REM:
            begin
                if (status.rem_zero)
                    cmd.commit = 1'b1;
                else
                    cmd.next_div = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule : sps_ctrl
`default_nettype wire

// File: rtl/core/sps_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_datapath
// scan state, configuration registers, trial divisor with running square,
// multi-bit restoring remainder unit, totals, recent prime window and
// output register
// ----------------------------------------------------------------------------
module sps_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [sps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sps_pkg::CFG_BITS-1:0]       cfg_data,
    input  wire logic                               restart,
    input  wire sps_pkg::dp_cmd_t                   cmd,
    output sps_pkg::dp_status_t                     status,
    output logic [sps_pkg::VALUE_BITS-1:0]          candidate,
    output logic                                    is_prime,
    output logic [sps_pkg::COUNT_BITS-1:0]          found_count,
    output logic [sps_pkg::SUM_BITS-1:0]            found_sum,
    output logic [sps_pkg::VALUE_BITS-1:0]          oldest_kept,
    output logic [sps_pkg::KEPT_BITS-1:0]           kept_count,
    output logic                                    done_res
);
    import sps_pkg::*;

    // configuration
    logic [CFG_BITS-1:0]   start_value_reg;
    logic [CFG_BITS-1:0]   max_value_reg;

    // scan state
    logic [VALUE_BITS-1:0] next_cand_reg;
    logic [VALUE_BITS-1:0] next_cand_next;
    logic                  past_end_reg;
    logic                  past_end_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [SUM_BITS-1:0]   sum_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic [WIN_IDX_W-1:0]  head_reg;
    logic [WIN_IDX_W-1:0]  head_next;
    logic [VALUE_BITS-1:0] recent_reg [WINDOW_DEPTH];

    // trial division
    logic [DIV_W-1:0]      divisor_reg;
    logic [SQ_W-1:0]       square_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      rem_next;
    logic [DIV_PAD-1:0]    dividend_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;

    // step result
    logic [VALUE_BITS-1:0] res_cand_reg;
    logic                  res_prime_reg;
    logic                  res_done_reg;

    // output register
    logic [VALUE_BITS-1:0] out_cand_reg;
    logic                  out_prime_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [SUM_BITS-1:0]   out_sum_reg;
    logic [VALUE_BITS-1:0] out_oldest_reg;
    logic [KEPT_BITS-1:0]  out_kept_reg;
    logic                  out_done_reg;

    logic [VALUE_BITS:0]   stepped;
    logic [FILL_W:0]       slot_sum;
    logic [WIN_IDX_W-1:0]  slot;
    logic                  window_full;
    logic [VALUE_BITS-1:0] oldest;
    logic [KEPT_BITS-1:0]  kept;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= START_VALUE_RESET;
            max_value_reg   <= MAX_VALUE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_START_VALUE)
                start_value_reg <= cfg_data;
            if (cfg_index == REG_MAX_VALUE)
                max_value_reg <= cfg_data;
        end
    end

    // status
    assign status.scan_done = past_end_reg ||
                              (CFG_BITS'(next_cand_reg) > max_value_reg);
    assign status.sq_over   = square_reg > SQ_W'(next_cand_reg);
    assign status.div_last  = div_cnt_reg == '0;
    assign status.rem_zero  = rem_reg == '0;

    // candidate advance and window slot
    assign stepped     = {1'b0, next_cand_reg} + (VALUE_BITS + 1)'(STRIDE);
    assign slot_sum    = (FILL_W + 1)'(head_reg) + (FILL_W + 1)'(fill_reg);
    assign slot        = (slot_sum >= (FILL_W + 1)'(WINDOW_DEPTH)) ?
                         WIN_IDX_W'(slot_sum - (FILL_W + 1)'(WINDOW_DEPTH)) :
                         WIN_IDX_W'(slot_sum);
    assign window_full = fill_reg == FILL_W'(WINDOW_DEPTH);

    always_comb
    begin
        next_cand_next = next_cand_reg;
        past_end_next  = past_end_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        priority if (cmd.accept && restart)
        begin
            next_cand_next = VALUE_BITS'(start_value_reg);
            past_end_next  = 1'b0;
            count_next     = '0;
            sum_next       = '0;
            fill_next      = '0;
            head_next      = '0;
        end
        else if (cmd.commit)
        begin
            if (cmd.commit_prime)
            begin
                count_next = count_reg + COUNT_BITS'(1);
                sum_next   = sum_reg + SUM_BITS'(next_cand_reg);
                if (!window_full)
                    fill_next = fill_reg + FILL_W'(1);
                else if (head_reg == WIN_IDX_W'(WINDOW_DEPTH - 1))
                    head_next = '0;
                else
                    head_next = head_reg + WIN_IDX_W'(1);
            end
            if (stepped[VALUE_BITS])
                past_end_next = 1'b1;
            else
                next_cand_next = stepped[VALUE_BITS-1:0];
        end
        else
        begin
            next_cand_next = next_cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_cand_reg <= VALUE_BITS'(START_VALUE_RESET);
            past_end_reg  <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
        end
        else
        begin
            next_cand_reg <= next_cand_next;
            past_end_reg  <= past_end_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && cmd.commit_prime)
            recent_reg[slot] <= next_cand_reg;
    end

    // remainder unit, DIV_STEP dividend bits per cycle
    always_comb
    begin
        logic [DIV_W:0] trial;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {rem_next, dividend_reg[DIV_PAD-1-i]};
            if (trial >= {1'b0, divisor_reg})
                trial = trial - {1'b0, divisor_reg};
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.test_init)
        begin
            divisor_reg <= DIV_W'(FIRST_DIVISOR);
            square_reg  <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
        end
        else if (cmd.next_div)
        begin
            divisor_reg <= divisor_reg + DIV_W'(2);
            square_reg  <= square_reg + SQ_W'({divisor_reg, 2'b00}) + SQ_W'(4);
        end

        if (cmd.div_init)
        begin
            rem_reg      <= '0;
            dividend_reg <= DIV_PAD'(next_cand_reg);
            div_cnt_reg  <= DIV_CNT_W'(DIV_CYCLES - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg      <= rem_next;
            dividend_reg <= dividend_reg << DIV_STEP;
            div_cnt_reg  <= div_cnt_reg - DIV_CNT_W'(1);
        end
    end

    // step result
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_cand_reg  <= next_cand_reg;
            res_prime_reg <= cmd.commit_prime;
            res_done_reg  <= 1'b0;
        end
        else if (cmd.commit_done)
        begin
            res_cand_reg  <= '0;
            res_prime_reg <= 1'b0;
            res_done_reg  <= 1'b1;
        end
    end

    assign oldest = (fill_reg != '0) ? recent_reg[head_reg] : '0;
    assign kept   = (int'(fill_reg) > KEPT_MAX) ? KEPT_BITS'(KEPT_MAX) :
                                                  KEPT_BITS'(fill_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_cand_reg   <= res_cand_reg;
            out_prime_reg  <= res_prime_reg;
            out_count_reg  <= count_reg;
            out_sum_reg    <= sum_reg;
            out_oldest_reg <= oldest;
            out_kept_reg   <= kept;
            out_done_reg   <= res_done_reg;
        end
    end

    assign candidate   = out_cand_reg;
    assign is_prime    = out_prime_reg;
    assign found_count = out_count_reg;
    assign found_sum   = out_sum_reg;
    assign oldest_kept = out_oldest_reg;
    assign kept_count  = out_kept_reg;
    assign done_res    = out_done_reg;

endmodule : sps_datapath
`default_nettype wire

// File: rtl/core/strided_prime_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// strided_prime_scan
// strided trial-division prime scanner with running count, sum and a window
// of the most recent primes
// ----------------------------------------------------------------------------
// One input transaction advances the scan by one candidate (or restarts it at
// start_value, clearing count, sum and window) and yields exactly one result
// transaction. Items are handled one at a time: a done step passes only through
// the end check, otherwise each of the k odd trial divisors checked (k up to
// about sqrt(candidate) / 2) takes a square test, the division steps and a
// remainder check. Most of a step is spent in the single shared remainder
// unit, which retires 4 dividend bits per cycle.
// A finished result waits in the output register while the next transaction
// is accepted. A start_value write takes effect at the next restart; a
// max_value write applies from the next end check.
module strided_prime_scan (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [sps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sps_pkg::CFG_BITS-1:0]       cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               restart,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [sps_pkg::VALUE_BITS-1:0]          candidate,
    output logic                                    is_prime,
    output logic [sps_pkg::COUNT_BITS-1:0]          found_count,
    output logic [sps_pkg::SUM_BITS-1:0]            found_sum,
    output logic [sps_pkg::VALUE_BITS-1:0]          oldest_kept,
    output logic [sps_pkg::KEPT_BITS-1:0]           kept_count,
    output logic                                    done_res
);
    import sps_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sps_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .restart     (restart),
        .cmd         (cmd),
        .status      (status),
        .candidate   (candidate),
        .is_prime    (is_prime),
        .found_count (found_count),
        .found_sum   (found_sum),
        .oldest_kept (oldest_kept),
        .kept_count  (kept_count),
        .done_res    (done_res)
    );

endmodule : strided_prime_scan
`default_nettype wire

// File: dv/strided_prime_scan_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strided_prime_scan_test
// self-checking testbench for the strided prime scanner
// ----------------------------------------------------------------------------
// A directed table covers reset values, even and sub-3 candidates, the done
// state, running off the top of the value range, deferred and ignored
// register writes. Random scans follow under many register settings, with
// bursty idling on both channels and one long output hold-off. Each result is
// checked field by field against a table entry or an in-bench scan model.
module strided_prime_scan_test;

    import sps_pkg::*;

    localparam int CYCLE_LIMIT  = 25_000_000;
    localparam int RANDOM_STEPS = 100;
    localparam int CALM_AFTER   = 85;
    localparam int HOLD_CYCLES  = 4000;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [VALUE_BITS-1:0]  VALUE_MAX     = '1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = REG_MAX_VALUE + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = '1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] cand;
        logic                  prime;
        logic [COUNT_BITS-1:0] count;
        logic [SUM_BITS-1:0]   total;
        logic [VALUE_BITS-1:0] oldest;
        logic [KEPT_BITS-1:0]  kept;
        logic                  done;
    } scan_result_t;

    typedef enum logic {
        ROW_STEP,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_BITS-1:0]   data;
        logic                  restart_req;
        logic                  typed;
        scan_result_t          want;
    } plan_row_t;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [CFG_BITS-1:0]         cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic                        restart   = 1'b0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [VALUE_BITS-1:0]       candidate;
    logic                        is_prime;
    logic [COUNT_BITS-1:0]       found_count;
    logic [SUM_BITS-1:0]         found_sum;
    logic [VALUE_BITS-1:0]       oldest_kept;
    logic [KEPT_BITS-1:0]        kept_count;
    logic                        done_res;

    // scan model state
    logic [CFG_BITS-1:0]   reg_start = START_VALUE_RESET;
    logic [CFG_BITS-1:0]   reg_max   = MAX_VALUE_RESET;
    logic [VALUE_BITS-1:0] scan_next = START_VALUE_RESET;
    logic [COUNT_BITS-1:0] primes_found = '0;
    logic [SUM_BITS-1:0]   primes_total = '0;
    logic [VALUE_BITS-1:0] ring [WINDOW_DEPTH];
    int                    ring_head = 0;
    int                    ring_fill = 0;
    bit                    ran_off_end = 1'b0;

    scan_result_t results_due[$];
    scan_result_t front;
    plan_row_t    plan[$];

    int  mismatches      = 0;
    int  results_checked = 0;
    int  primes_reported = 0;
    int  done_reported   = 0;
    int  steps_sent      = 0;
    int  settings_used   = 0;
    int  cycles          = 0;
    bit  calm            = 1'b0;
    bit  squeeze_now     = 1'b0;
    bit  squeezed        = 1'b0;
    bit  out_gaps        = 1'b1;

    strided_prime_scan dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .candidate   (candidate),
        .is_prime    (is_prime),
        .found_count (found_count),
        .found_sum   (found_sum),
        .oldest_kept (oldest_kept),
        .kept_count  (kept_count),
        .done_res    (done_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic has_no_odd_factor(input logic [VALUE_BITS-1:0] n);
        longint unsigned d;
        for (d = FIRST_DIVISOR; d * d <= n; d += 2)
        begin
            if (n % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic scan_result_t advance_scan(input logic restart_req);
        scan_result_t r;
        logic [VALUE_BITS:0] following;
        r = '0;
        if (restart_req)
        begin
            scan_next    = reg_start;
            primes_found = '0;
            primes_total = '0;
            ring_head    = 0;
            ring_fill    = 0;
            ran_off_end  = 1'b0;
        end
        if (ran_off_end || scan_next > reg_max)
        begin
            r.done = 1'b1;
        end
        else
        begin
            r.cand = scan_next;
            if (has_no_odd_factor(scan_next))
            begin
                r.prime = 1'b1;
                primes_found += 1'b1;
                primes_total += SUM_BITS'(scan_next);
                ring[(ring_head + ring_fill) % WINDOW_DEPTH] = scan_next;
                if (ring_fill < WINDOW_DEPTH)
                    ring_fill++;
                else
                    ring_head = (ring_head + 1) % WINDOW_DEPTH;
            end
            following = {1'b0, scan_next} + (VALUE_BITS + 1)'(STRIDE);
            if (following > VALUE_MAX)
                ran_off_end = 1'b1;
            else
                scan_next = following[VALUE_BITS-1:0];
        end
        r.count  = primes_found;
        r.total  = primes_total;
        r.oldest = (ring_fill != 0) ? ring[ring_head] : '0;
        r.kept   = (ring_fill > KEPT_MAX) ? KEPT_BITS'(KEPT_MAX) : KEPT_BITS'(ring_fill);
        return r;
    endfunction

    function automatic plan_row_t step_row(input logic r);
        return '{kind: ROW_STEP, idx: '0, data: '0, restart_req: r, typed: 1'b0, want: '0};
    endfunction

    function automatic plan_row_t checked_row(input logic r, input scan_result_t want);
        return '{kind: ROW_STEP, idx: '0, data: '0, restart_req: r, typed: 1'b1, want: want};
    endfunction

    function automatic plan_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_BITS-1:0] data);
        return '{kind: ROW_WRITE, idx: idx, data: data, restart_req: 1'b0, typed: 1'b0,
                 want: '0};
    endfunction

    function automatic void add_row(input plan_row_t row);
        plan.insert(plan.size(), row);
    endfunction

    task automatic send_step(input logic restart_req, input logic typed,
                             input scan_result_t want);
        scan_result_t predicted;
        in_valid <= 1'b1;
        restart  <= restart_req;
        do @(posedge clk); while (!in_ready);
        predicted = advance_scan(restart_req);
        results_due.insert(results_due.size(), typed ? want : predicted);
        steps_sent++;
    endtask

    task automatic pause_in(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_START_VALUE)
            reg_start = data;
        else if (idx == REG_MAX_VALUE)
            reg_max = data;
        @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // result transactions
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none actual %0d",
                         $time, candidate);
                mismatches++;
            end
            else
            begin
                front = results_due.pop_front();
                check_field("candidate", 64'(front.cand), 64'(candidate));
                check_field("is_prime", 64'(front.prime), 64'(is_prime));
                check_field("found_count", 64'(front.count), 64'(found_count));
                check_field("found_sum", 64'(front.total), 64'(found_sum));
                check_field("oldest_kept", 64'(front.oldest), 64'(oldest_kept));
                check_field("kept_count", 64'(front.kept), 64'(kept_count));
                check_field("done_res", 64'(front.done), 64'(done_res));
                results_checked++;
                primes_reported += int'(front.prime);
                done_reported   += int'(front.done);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, results_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random hold-offs and one long squeeze
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze_now && !squeezed)
            begin
                squeezed = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && out_gaps && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            if ($urandom_range(0, 99) == 0)
                out_gaps = !out_gaps;
        end
    end

    initial
    begin
        logic [CFG_BITS-1:0] first;
        logic [CFG_BITS-1:0] last;
        int  span;
        int  phase;
        int  random_sent;
        bit  wide;
        bit  prev_wide;
        bit  restart_now;
        bit  in_gaps;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(checked_row(1'b0, '{3, 1, 1, 3, 3, 1, 0}));
        add_row(checked_row(1'b0, '{19, 1, 2, 22, 3, 2, 0}));
        add_row(step_row(1'b0));
        // new start value only applies at the next restart
        add_row(write_row(REG_START_VALUE, 4));
        add_row(write_row(REG_MAX_VALUE, 200));
        add_row(step_row(1'b0));
        add_row(checked_row(1'b1, '{4, 1, 1, 4, 4, 1, 0}));
        add_row(step_row(1'b0));
        add_row(write_row(REG_START_VALUE, 1));
        add_row(checked_row(1'b1, '{1, 1, 1, 1, 1, 1, 0}));
        // smallest range: one candidate, then done until restart
        add_row(write_row(REG_START_VALUE, 3));
        add_row(write_row(REG_MAX_VALUE, 3));
        add_row(checked_row(1'b1, '{3, 1, 1, 3, 3, 1, 0}));
        add_row(checked_row(1'b0, '{0, 0, 1, 3, 3, 1, 1}));
        add_row(checked_row(1'b0, '{0, 0, 1, 3, 3, 1, 1}));
        add_row(write_row(REG_START_VALUE, 5));
        add_row(checked_row(1'b1, '{0, 0, 0, 0, 0, 0, 1}));
        // writes to unused indexes must be dropped
        add_row(write_row(REG_UNUSED_LO, '1));
        add_row(write_row(REG_UNUSED_HI, '0));
        add_row(checked_row(1'b1, '{0, 0, 0, 0, 0, 0, 1}));
        // top of the value range
        add_row(write_row(REG_MAX_VALUE, VALUE_MAX));
        add_row(write_row(REG_START_VALUE, VALUE_MAX - CFG_BITS'(STRIDE)));
        add_row(step_row(1'b1));
        add_row(step_row(1'b0));
        add_row(step_row(1'b0));
        add_row(step_row(1'b0));
        add_row(write_row(REG_START_VALUE, VALUE_MAX));
        add_row(step_row(1'b1));
        add_row(step_row(1'b0));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_step(plan[i].restart_req, plan[i].typed, plan[i].want);
            end
        end

        phase       = 0;
        random_sent = 0;
        prev_wide   = 1'b0;
        while (random_sent < RANDOM_STEPS)
        begin
            wide = (phase % 6 == 5);
            span = wide ? 2 : $urandom_range(8, 20);
            drain();
            if (wide)
            begin
                first = CFG_BITS'($urandom_range(3, VALUE_MAX));
                last  = $urandom_range(0, 1) ? VALUE_MAX :
                                               CFG_BITS'($urandom_range(3, VALUE_MAX));
            end
            else
            begin
                first = CFG_BITS'($urandom_range(3, 30000));
                if ($urandom_range(0, 3) != 0)
                    first[0] = 1'b1;
                case ($urandom_range(0, 3))
                    0:       last = VALUE_MAX;
                    1:       last = CFG_BITS'($urandom_range(3, first));
                    default: last = first + CFG_BITS'($urandom_range(0, STRIDE * span));
                endcase
            end
            write_reg(REG_START_VALUE, first);
            write_reg(REG_MAX_VALUE, last);
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          CFG_BITS'($urandom_range(0, VALUE_MAX)));
            settings_used++;
            restart_now = wide || prev_wide || ($urandom_range(0, 4) != 0);
            in_gaps     = ($urandom_range(0, 2) != 0);
            if (phase == 2)
                squeeze_now = 1'b1;
            for (int k = 0; k < span; k++)
            begin
                send_step((k == 0) ? restart_now : ($urandom_range(0, 11) == 0), 1'b0, '0);
                random_sent++;
                if (random_sent >= CALM_AFTER)
                    calm = 1'b1;
                if (!calm && in_gaps && $urandom_range(0, 3) == 0)
                    pause_in($urandom_range(1, 15));
            end
            prev_wide = wide;
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
            mismatches++;

        $display("ran %0d scan steps over %0d random register settings plus directed cases",
                 steps_sent, settings_used);
        $display("checked %0d results: %0d primes, %0d done steps, %0d mismatches",
                 results_checked, primes_reported, done_reported, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/sps_pkg.sv
rtl/core/sps_ctrl.sv
rtl/core/sps_datapath.sv
rtl/core/strided_prime_scan.sv
dv/strided_prime_scan_test.sv
